// File: design/tto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tto_pkg
// Shared constants, codes and command/status types of the terminal output
// post-processor.
// ----------------------------------------------------------------------------
package tto_pkg;

  localparam int TAB_STOP    = 8;
  localparam int DELAY_PIECE = 59;
  localparam int MAX_RESULTS = 8;

  localparam int CHAR_W    = 8;
  localparam int CH7_W     = 7;
  localparam int COL_W     = 8;
  localparam int DLY_W     = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = $clog2(MAX_RESULTS + 1);
  localparam int REM_W     = $clog2(TAB_STOP + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINARY,
    CFG_RAW,
    CFG_EXPAND_TABS,
    CFG_UPPER_ONLY,
    CFG_ESC_CAPS,
    CFG_CR_NL,
    CFG_ESC_TILDE,
    CFG_DELAY_SEL
  } cfg_idx_t;

  // character codes
  localparam logic [CH7_W-1:0] CH_EOT    = 7'h04;
  localparam logic [CH7_W-1:0] CH_BS     = 7'h08;
  localparam logic [CH7_W-1:0] CH_TAB    = 7'h09;
  localparam logic [CH7_W-1:0] CH_LF     = 7'h0A;
  localparam logic [CH7_W-1:0] CH_VT     = 7'h0B;
  localparam logic [CH7_W-1:0] CH_FF     = 7'h0C;
  localparam logic [CH7_W-1:0] CH_CR     = 7'h0D;
  localparam logic [CH7_W-1:0] CH_SPACE  = 7'h20;
  localparam logic [CH7_W-1:0] CH_BANG   = 7'h21;
  localparam logic [CH7_W-1:0] CH_QUOTE  = 7'h27;
  localparam logic [CH7_W-1:0] CH_LPAREN = 7'h28;
  localparam logic [CH7_W-1:0] CH_RPAREN = 7'h29;
  localparam logic [CH7_W-1:0] CH_CAP_A  = 7'h41;
  localparam logic [CH7_W-1:0] CH_CAP_Z  = 7'h5A;
  localparam logic [CH7_W-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CH7_W-1:0] CH_CARET  = 7'h5E;
  localparam logic [CH7_W-1:0] CH_GRAVE  = 7'h60;
  localparam logic [CH7_W-1:0] CH_LOW_A  = 7'h61;
  localparam logic [CH7_W-1:0] CH_LOW_Z  = 7'h7A;
  localparam logic [CH7_W-1:0] CH_LBRACE = 7'h7B;
  localparam logic [CH7_W-1:0] CH_BAR    = 7'h7C;
  localparam logic [CH7_W-1:0] CH_RBRACE = 7'h7D;
  localparam logic [CH7_W-1:0] CH_TILDE  = 7'h7E;
  localparam logic [CH7_W-1:0] CH_DEL    = 7'h7F;
  localparam logic [CH7_W-1:0] CASE_DIFF = 7'h20;

  // delay values in ticks
  localparam logic [DLY_W-1:0] DLY_LONG    = 7'd60;
  localparam logic [DLY_W-1:0] DLY_VERT    = 7'd127;
  localparam logic [DLY_W-1:0] DLY_NL_MIN  = 7'd6;
  localparam logic [DLY_W-1:0] DLY_NL_BASE = 7'd3;
  localparam logic [DLY_W-1:0] DLY_CR_ONE  = 7'd5;
  localparam logic [DLY_W-1:0] DLY_CR_TWO  = 7'd10;
  localparam logic [DLY_W-1:0] DLY_TAB_MIN = 7'd5;

  localparam logic [1:0] DT_ONE = 2'd1;
  localparam logic [1:0] DT_TWO = 2'd2;

  typedef enum logic [2:0] {
    OP_BIN,
    OP_SPACE,
    OP_PRE,
    OP_MAIN,
    OP_DLY_PRE,
    OP_DLY_MAIN
  } op_t;

  typedef struct packed {
    logic load;
    logic emit;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic dec_bin;
    logic dec_drop;
    logic dec_tab;
    logic dec_pre;
    logic ch_dly_nz;
    logic dly_done;
    logic space_done;
  } dp_stat_t;

endpackage

// File: design/tto_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tto_if
// Valid/ready channels: the character input and the line byte output.
// ----------------------------------------------------------------------------
interface tto_char_if;
  logic                       valid;
  logic                       ready;
  logic [tto_pkg::CHAR_W-1:0] out_char;

  modport source (output valid, output out_char, input ready);
  modport sink (input valid, input out_char, output ready);
endinterface

interface tto_byte_if;
  logic                       valid;
  logic                       ready;
  logic [tto_pkg::CHAR_W-1:0] out_byte;
  logic [tto_pkg::COL_W-1:0]  column_now;
  logic                       last;

  modport source (output valid, output out_byte, output column_now, output last,
                  input ready);
  modport sink (input valid, input out_byte, input column_now, input last,
                output ready);
endinterface

// File: design/tto_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tto_dp
// Datapath: configuration registers, character decode, column tracking,
// delay splitting and the output register.
// ----------------------------------------------------------------------------
module tto_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tto_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tto_pkg::CFG_W-1:0]        cfg_data,
  input  logic [tto_pkg::CHAR_W-1:0]       in_char,
  input  tto_pkg::dp_cmd_t                 cmd,
  output tto_pkg::dp_stat_t                stat,
  output logic [tto_pkg::CHAR_W-1:0]       out_byte,
  output logic [tto_pkg::COL_W-1:0]        column_now,
  output logic                             last
);

  logic                        bin_r, raw_r, tabs_r, upper_r;
  logic                        esc_caps_r, cr_nl_r, esc_tilde_r;
  logic [tto_pkg::DLY_W-1:0]   dsel_r;

  logic [tto_pkg::COL_W-1:0]   column_r, column_nxt;
  logic [tto_pkg::DLY_W-1:0]   delay_r, delay_nxt;
  logic [tto_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tto_pkg::CH7_W-1:0]   pre_r;
  logic [tto_pkg::CHAR_W-1:0]  main_r;
  logic [tto_pkg::CHAR_W-1:0]  byte_r, byte_nxt;
  logic [tto_pkg::COL_W-1:0]   colnow_r, colnow_nxt;
  logic                        last_r, last_nxt;

  // decode
  logic [tto_pkg::CH7_W-1:0]   c7, mapped, pre_ch;
  logic                        pre_hit;

  // send unit
  logic [tto_pkg::CH7_W-1:0]   ch;
  logic [tto_pkg::COL_W:0]     sum_one, sum_tab;
  logic [tto_pkg::COL_W-1:0]   inc_col, send_col;
  logic [tto_pkg::REM_W-1:0]   tab_rem;
  logic [tto_pkg::DLY_W-1:0]   nl_d, send_d;

  // delay split
  logic [tto_pkg::DLY_W-1:0]   piece, dly_left;
  logic [tto_pkg::CNT_W-1:0]   cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r       <= 1'b0;
      raw_r       <= 1'b0;
      tabs_r      <= 1'b0;
      upper_r     <= 1'b0;
      esc_caps_r  <= 1'b0;
      cr_nl_r     <= 1'b0;
      esc_tilde_r <= 1'b0;
      dsel_r      <= '0;
    end else if (cfg_we) begin
      case (tto_pkg::cfg_idx_t'(cfg_index))
        tto_pkg::CFG_BINARY:      bin_r       <= cfg_data[0];
        tto_pkg::CFG_RAW:         raw_r       <= cfg_data[0];
        tto_pkg::CFG_EXPAND_TABS: tabs_r      <= cfg_data[0];
        tto_pkg::CFG_UPPER_ONLY:  upper_r     <= cfg_data[0];
        tto_pkg::CFG_ESC_CAPS:    esc_caps_r  <= cfg_data[0];
        tto_pkg::CFG_CR_NL:       cr_nl_r     <= cfg_data[0];
        tto_pkg::CFG_ESC_TILDE:   esc_tilde_r <= cfg_data[0];
        tto_pkg::CFG_DELAY_SEL:   dsel_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the incoming item into an optional prefix character and the main one.
  always_comb begin
    c7      = in_char[tto_pkg::CH7_W-1:0];
    mapped  = c7;
    pre_ch  = tto_pkg::CH_BSLASH;
    pre_hit = 1'b0;
    if (upper_r) begin
      case (c7)
        tto_pkg::CH_LBRACE: begin mapped = tto_pkg::CH_LPAREN; pre_hit = 1'b1; end
        tto_pkg::CH_RBRACE: begin mapped = tto_pkg::CH_RPAREN; pre_hit = 1'b1; end
        tto_pkg::CH_BAR:    begin mapped = tto_pkg::CH_BANG;   pre_hit = 1'b1; end
        tto_pkg::CH_TILDE:  begin mapped = tto_pkg::CH_CARET;  pre_hit = 1'b1; end
        tto_pkg::CH_GRAVE:  begin mapped = tto_pkg::CH_QUOTE;  pre_hit = 1'b1; end
        default: ;
      endcase
      if (mapped >= tto_pkg::CH_LOW_A && mapped <= tto_pkg::CH_LOW_Z)
        mapped = mapped - tto_pkg::CASE_DIFF;
      if (mapped >= tto_pkg::CH_CAP_A && mapped <= tto_pkg::CH_CAP_Z && esc_caps_r)
        pre_hit = 1'b1;
    end
    if (mapped == tto_pkg::CH_LF && cr_nl_r) begin
      pre_hit = 1'b1;
      pre_ch  = tto_pkg::CH_CR;
    end
    if (esc_tilde_r && mapped == tto_pkg::CH_TILDE) begin
      pre_hit = 1'b1;
      mapped  = tto_pkg::CH_CARET;
    end
  end

  // Send unit: column and delay after one 7-bit character.
  always_comb begin
    ch       = (cmd.op == tto_pkg::OP_PRE) ? pre_r : main_r[tto_pkg::CH7_W-1:0];
    sum_one  = {1'b0, column_r} + (tto_pkg::COL_W+1)'(1);
    inc_col  = sum_one[tto_pkg::COL_W] ? '1 : sum_one[tto_pkg::COL_W-1:0];
    tab_rem  = tto_pkg::REM_W'(tto_pkg::TAB_STOP)
               - tto_pkg::REM_W'(column_r % tto_pkg::TAB_STOP);
    sum_tab  = {1'b0, column_r} + (tto_pkg::COL_W+1)'(tab_rem);
    nl_d     = tto_pkg::DLY_W'(column_r >> 4) + tto_pkg::DLY_NL_BASE;
    send_col = column_r;
    send_d   = '0;
    case (ch)
      tto_pkg::CH_BS: begin
        if (column_r != '0) send_col = column_r - tto_pkg::COL_W'(1);
      end
      tto_pkg::CH_TAB: begin
        send_col = sum_tab[tto_pkg::COL_W] ? '1 : sum_tab[tto_pkg::COL_W-1:0];
        if (dsel_r[3:2] == tto_pkg::DT_ONE &&
            tto_pkg::DLY_W'(tab_rem) + tto_pkg::DLY_W'(1) >= tto_pkg::DLY_TAB_MIN)
          send_d = tto_pkg::DLY_W'(tab_rem) + tto_pkg::DLY_W'(1);
      end
      tto_pkg::CH_LF: begin
        send_col = '0;
        if (dsel_r[1:0] == tto_pkg::DT_ONE) begin
          if (column_r != '0)
            send_d = (nl_d < tto_pkg::DLY_NL_MIN) ? tto_pkg::DLY_NL_MIN : nl_d;
        end else if (dsel_r[1:0] == tto_pkg::DT_TWO) begin
          send_d = tto_pkg::DLY_NL_MIN;
        end
      end
      tto_pkg::CH_VT, tto_pkg::CH_FF: begin
        if (dsel_r[6]) send_d = tto_pkg::DLY_VERT;
      end
      tto_pkg::CH_CR: begin
        send_col = '0;
        if (dsel_r[5:4] == tto_pkg::DT_ONE)      send_d = tto_pkg::DLY_CR_ONE;
        else if (dsel_r[5:4] == tto_pkg::DT_TWO) send_d = tto_pkg::DLY_CR_TWO;
      end
      default: begin
        if (!(ch < tto_pkg::CH_SPACE || ch == tto_pkg::CH_DEL)) send_col = inc_col;
      end
    endcase
  end

  // Long delays go out in pieces while the remainder stays long.
  always_comb begin
    if (delay_r >= tto_pkg::DLY_LONG)
      piece = (tto_pkg::DLY_W'(tto_pkg::DELAY_PIECE) < delay_r) ?
              tto_pkg::DLY_W'(tto_pkg::DELAY_PIECE) : delay_r;
    else
      piece = delay_r;
    dly_left = delay_r - piece;
    cnt_inc  = cnt_r + tto_pkg::CNT_W'(1);
  end

  always_comb begin
    stat.dec_bin    = bin_r;
    stat.dec_drop   = !bin_r && c7 == tto_pkg::CH_EOT && !raw_r;
    stat.dec_tab    = !bin_r && c7 == tto_pkg::CH_TAB && tabs_r;
    stat.dec_pre    = pre_hit;
    stat.ch_dly_nz  = send_d != '0;
    stat.dly_done   = dly_left == '0;
    stat.space_done = (inc_col % tto_pkg::TAB_STOP) == 0 || inc_col == '1 ||
                      cnt_inc == tto_pkg::CNT_W'(tto_pkg::MAX_RESULTS);
  end

  always_comb begin
    column_nxt = column_r;
    delay_nxt  = delay_r;
    cnt_nxt    = cnt_r;
    byte_nxt   = main_r;
    colnow_nxt = column_r;
    last_nxt   = 1'b0;
    case (cmd.op)
      tto_pkg::OP_BIN: begin
        last_nxt = 1'b1;
      end
      tto_pkg::OP_SPACE: begin
        column_nxt = inc_col;
        cnt_nxt    = cnt_inc;
        byte_nxt   = {1'b0, tto_pkg::CH_SPACE};
        colnow_nxt = inc_col;
        last_nxt   = stat.space_done;
      end
      tto_pkg::OP_PRE, tto_pkg::OP_MAIN: begin
        column_nxt = send_col;
        delay_nxt  = send_d;
        byte_nxt   = {1'b0, ch};
        colnow_nxt = send_col;
        last_nxt   = cmd.op == tto_pkg::OP_MAIN && send_d == '0;
      end
      tto_pkg::OP_DLY_PRE, tto_pkg::OP_DLY_MAIN: begin
        delay_nxt  = dly_left;
        byte_nxt   = {1'b1, piece};
        last_nxt   = cmd.op == tto_pkg::OP_DLY_MAIN && dly_left == '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
    end else if (cmd.emit) begin
      column_r <= column_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre_r  <= pre_ch;
      main_r <= bin_r ? in_char : {1'b0, mapped};
      cnt_r  <= '0;
    end else if (cmd.emit) begin
      cnt_r  <= cnt_nxt;
    end
    if (cmd.emit) begin
      delay_r  <= delay_nxt;
      byte_r   <= byte_nxt;
      colnow_r <= colnow_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_byte   = byte_r;
  assign column_now = colnow_r;
  assign last       = last_r;

endmodule

// File: design/tto_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tto_ctrl
// Controller: steps one item through binary, space, prefix, character and
// delay bytes and owns the channel handshakes.
// ----------------------------------------------------------------------------
module tto_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tto_pkg::dp_stat_t stat,
  output tto_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_SPACE,
    S_PRE,
    S_DLY_PRE,
    S_MAIN,
    S_DLY_MAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_emit;

  assign can_emit = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.op    = tto_pkg::OP_MAIN;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.dec_bin)       state_nxt = S_BIN;
          else if (stat.dec_drop) state_nxt = S_IDLE;
          else if (stat.dec_tab)  state_nxt = S_SPACE;
          else if (stat.dec_pre)  state_nxt = S_PRE;
          else                    state_nxt = S_MAIN;
        end
      end
      S_BIN: begin
        cmd.op = tto_pkg::OP_BIN;
        if (can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SPACE: begin
        cmd.op = tto_pkg::OP_SPACE;
        if (can_emit) begin
          cmd.emit = 1'b1;
          if (stat.space_done) state_nxt = S_IDLE;
        end
      end
      S_PRE: begin
        cmd.op = tto_pkg::OP_PRE;
        if (can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.ch_dly_nz ? S_DLY_PRE : S_MAIN;
        end
      end
      S_DLY_PRE: begin
        cmd.op = tto_pkg::OP_DLY_PRE;
        if (can_emit) begin
          cmd.emit = 1'b1;
          if (stat.dly_done) state_nxt = S_MAIN;
        end
      end
      S_MAIN: begin
        cmd.op = tto_pkg::OP_MAIN;
        if (can_emit) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.ch_dly_nz ? S_DLY_MAIN : S_IDLE;
        end
      end
      S_DLY_MAIN: begin
        cmd.op = tto_pkg::OP_DLY_MAIN;
        if (can_emit) begin
          cmd.emit = 1'b1;
          if (stat.dly_done) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: design/tty_output_postprocessor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_output_postprocessor_top
// Terminal output post-processor: one character in, the line bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one character item per handshake (valid/ready).
//   out_ch : line bytes with the column after each byte; last marks the
//            final byte caused by an item. Non-binary bytes with bit 7 set are delays.
//   cfg_*  : register writes; issue them only while no item is in work.
// Flow: an item is taken in the idle state, then each of its bytes leaves the
//   controller one per cycle while out_ch does not stall.
//   The controller steps through binary, space, prefix, character and delay
//   bytes one at a time; a dropped EOT is only accepted and sends no byte.
// The output register frees the controller as soon as a byte is loaded; the
//   next item is accepted while the last byte still waits on out_ch.
// When the receiver stalls, the pending byte holds and the controller waits
//   with the following one.
// Reset clears the configuration, the column and the controller; nothing is
//   emitted until an item arrives.
// ----------------------------------------------------------------------------
module tty_output_postprocessor_top (
  input  logic                          clk,
  input  logic                          rst_n,
  tto_char_if.sink                      in_ch,
  tto_byte_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [tto_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tto_pkg::CFG_W-1:0]     cfg_data
);

  tto_pkg::dp_cmd_t  cmd;
  tto_pkg::dp_stat_t stat;
  logic              in_ready, out_valid;

  tto_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tto_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_char    (in_ch.out_char),
    .cmd        (cmd),
    .stat       (stat),
    .out_byte   (out_ch.out_byte),
    .column_now (out_ch.column_now),
    .last       (out_ch.last)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  // a pending byte that is not the last one means the item is still in work
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> !in_ch.ready)
    else $error("input ready while an item still has bytes to send");

  // anything other than an EOT keeps the controller busy after acceptance
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.out_char[6:0] != tto_pkg::CH_EOT
    |=> !in_ch.ready)
    else $error("controller idle right after accepting an item");

  // a new byte only appears from a busy controller
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("byte emitted while the controller was idle");

endmodule

// File: sim/tb_tty_output_postprocessor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tty_output_postprocessor_top
// Self-checking bench for the terminal output post-processor. A built-in
// predictor tracks the print column and mode registers. It expands each
// accepted character into its line bytes, and every byte leaving the block
// is checked in order. Directed cases cover the modes and delay classes.
// Random text phases follow, along with column saturation and a long
// receiver stall.
// ----------------------------------------------------------------------------
module tb_tty_output_postprocessor_top;
  import tto_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] line_byte;
    logic [COL_W-1:0]  col;
    logic              last;
  } line_byte_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  tto_char_if in_ch ();
  tto_byte_if out_ch ();

  tty_output_postprocessor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic             binary_on, raw_on, tabs_on, upper_on, caps_on, crnl_on, tilde_on;
  logic [DLY_W-1:0] delay_sel;
  logic [COL_W-1:0] print_col;

  line_byte_t line_bytes_due[$];
  line_byte_t char_out[$];

  int error_count = 0;
  int stall_left  = 0;
  bit steady_in   = 0;
  bit steady_out  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [COL_W-1:0] sat_inc(logic [COL_W-1:0] a, int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 255) ? 8'd255 : 8'(s);
  endfunction

  function automatic void emit_byte(logic [CHAR_W-1:0] b);
    line_byte_t t;
    if (char_out.size() < MAX_RESULTS) begin
      t.line_byte = b;
      t.col       = print_col;
      t.last      = 1'b0;
      char_out.push_back(t);
    end
  endfunction

  function automatic void emit_delay(int unsigned ticks);
    int unsigned piece;
    if (ticks == 0) return;
    if (ticks < DLY_LONG) begin
      emit_byte(8'(ticks) | 8'h80);
    end else begin
      // split long delays, keep the remainder for last
      while (ticks >= DLY_LONG) begin
        piece = (DELAY_PIECE < ticks) ? DELAY_PIECE : ticks;
        ticks -= piece;
        emit_byte(8'(piece) | 8'h80);
      end
      if (ticks != 0) emit_byte(8'(ticks) | 8'h80);
    end
  endfunction

  // One 7-bit character: column moves first, the byte carries the new column.
  function automatic void emit_char(logic [CH7_W-1:0] c);
    int unsigned ticks;
    int unsigned gap;
    ticks = 0;
    case (c)
      CH_BS: begin
        if (print_col != 0) print_col = print_col - 1'b1;
      end
      CH_TAB: begin
        gap = TAB_STOP - print_col % TAB_STOP;
        if (delay_sel[3:2] == DT_ONE) begin
          ticks = gap + 1;
          if (ticks < DLY_TAB_MIN) ticks = 0;
        end
        print_col = sat_inc(print_col, gap);
      end
      CH_LF: begin
        if (delay_sel[1:0] == DT_ONE) begin
          if (print_col != 0) begin
            ticks = (print_col >> 4) + DLY_NL_BASE;
            if (ticks < DLY_NL_MIN) ticks = DLY_NL_MIN;
          end
        end else if (delay_sel[1:0] == DT_TWO) begin
          ticks = DLY_NL_MIN;
        end
        print_col = '0;
      end
      CH_VT, CH_FF: begin
        if (delay_sel[6]) ticks = DLY_VERT;
      end
      CH_CR: begin
        if (delay_sel[5:4] == DT_ONE) ticks = DLY_CR_ONE;
        else if (delay_sel[5:4] == DT_TWO) ticks = DLY_CR_TWO;
        print_col = '0;
      end
      default: begin
        if (c >= CH_SPACE && c != CH_DEL) print_col = sat_inc(print_col, 1);
      end
    endcase
    emit_byte({1'b0, c});
    emit_delay(ticks);
  endfunction

  function automatic void predict_line_bytes(logic [CHAR_W-1:0] full);
    logic [CH7_W-1:0] c;
    line_byte_t       t;
    c = full[CH7_W-1:0];
    char_out.delete();
    if (binary_on) begin
      emit_byte(full);
    end else if (c == CH_EOT && !raw_on) begin
      // drop: nothing goes out
    end else if (c == CH_TAB && tabs_on) begin
      do begin
        print_col = sat_inc(print_col, 1);
        emit_byte({1'b0, CH_SPACE});
      end while (print_col % TAB_STOP != 0 && print_col != 8'd255 &&
                 char_out.size() < MAX_RESULTS);
    end else begin
      if (upper_on) begin
        case (c)
          CH_LBRACE: begin emit_char(CH_BSLASH); c = CH_LPAREN; end
          CH_RBRACE: begin emit_char(CH_BSLASH); c = CH_RPAREN; end
          CH_BAR:    begin emit_char(CH_BSLASH); c = CH_BANG;   end
          CH_TILDE:  begin emit_char(CH_BSLASH); c = CH_CARET;  end
          CH_GRAVE:  begin emit_char(CH_BSLASH); c = CH_QUOTE;  end
          default: ;
        endcase
        if (c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_DIFF;
        if (c >= CH_CAP_A && c <= CH_CAP_Z && caps_on) emit_char(CH_BSLASH);
      end
      if (c == CH_LF && crnl_on) emit_char(CH_CR);
      if (tilde_on && c == CH_TILDE) begin
        emit_char(CH_BSLASH);
        emit_char(CH_CARET);
      end else begin
        emit_char(c);
      end
    end
    foreach (char_out[i]) begin
      t = char_out[i];
      t.last = (i == char_out.size() - 1);
      line_bytes_due.push_back(t);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  task automatic check_line_byte();
    line_byte_t want;
    if (line_bytes_due.size() == 0) begin
      error_count++;
      if (error_count <= 10)
        $display("unexpected byte %02h col %0d last %0b", out_ch.out_byte,
                 out_ch.column_now, out_ch.last);
    end else begin
      want = line_bytes_due.pop_front();
      if (out_ch.out_byte !== want.line_byte || out_ch.column_now !== want.col ||
          out_ch.last !== want.last) begin
        error_count++;
        if (error_count <= 10)
          $display("mismatch: got byte %02h col %0d last %0b, want %02h col %0d last %0b",
                   out_ch.out_byte, out_ch.column_now, out_ch.last,
                   want.line_byte, want.col, want.last);
      end
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_line_byte();
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (steady_out) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 38);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register writes
  // --------------------------------------------------------------------------
  task automatic send_char_item(input logic [CHAR_W-1:0] ch);
    int gap;
    gap = 0;
    while (!steady_in && $urandom_range(99) < 38) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.out_char <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_line_bytes(ch);
  endtask

  // Wait out every pending byte, plus slack for a dropped EOT still in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (line_bytes_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_BINARY:      binary_on = val[0];
      CFG_RAW:         raw_on    = val[0];
      CFG_EXPAND_TABS: tabs_on   = val[0];
      CFG_UPPER_ONLY:  upper_on  = val[0];
      CFG_ESC_CAPS:    caps_on   = val[0];
      CFG_CR_NL:       crnl_on   = val[0];
      CFG_ESC_TILDE:   tilde_on  = val[0];
      CFG_DELAY_SEL:   delay_sel = val;
      default: ;
    endcase
  endtask

  // Flags take bit 0 only; the upper data bits are junk on purpose.
  task automatic set_modes(input bit bin, input bit raw, input bit tabs, input bit upper,
                           input bit caps, input bit crnl, input bit tilde,
                           input logic [DLY_W-1:0] dsel);
    write_reg(CFG_BINARY,      {6'($urandom), bin});
    write_reg(CFG_RAW,         {6'($urandom), raw});
    write_reg(CFG_EXPAND_TABS, {6'($urandom), tabs});
    write_reg(CFG_UPPER_ONLY,  {6'($urandom), upper});
    write_reg(CFG_ESC_CAPS,    {6'($urandom), caps});
    write_reg(CFG_CR_NL,       {6'($urandom), crnl});
    write_reg(CFG_ESC_TILDE,   {6'($urandom), tilde});
    write_reg(CFG_DELAY_SEL,   dsel);
    cfg_we <= 1'b0;
  endtask

  task automatic set_random_modes(input bit allow_binary);
    set_modes(allow_binary && ($urandom_range(7) == 0), 1'($urandom), 1'($urandom),
              1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              7'($urandom));
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(99);
    k    = $urandom_range(12);
    if (roll < 40) return 8'($urandom_range(8'h7E, 8'h20));
    if (roll < 58) begin
      case (k)
        0: return {1'b0, CH_EOT};
        1: return {1'b0, CH_BS};
        2: return {1'b0, CH_TAB};
        3: return {1'b0, CH_LF};
        4: return {1'b0, CH_VT};
        5: return {1'b0, CH_FF};
        6: return {1'b0, CH_CR};
        7: return {1'b0, CH_DEL};
        8: return {1'b0, CH_LBRACE};
        9: return {1'b0, CH_RBRACE};
        10: return {1'b0, CH_BAR};
        11: return {1'b0, CH_TILDE};
        default: return {1'b0, CH_GRAVE};
      endcase
    end
    if (roll < 68) return 8'($urandom_range(8'h7A, 8'h61));
    if (roll < 85) return 8'($urandom);
    return 8'($urandom_range(8'h1F, 8'h00));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_binary_passthrough();
    set_modes(1, 0, 0, 0, 0, 0, 0, 7'h7F);
    send_char_item(8'hFF);
    send_char_item({1'b0, CH_LF});
    drain();
  endtask

  task automatic test_eot_and_controls();
    set_modes(0, 0, 0, 0, 0, 0, 0, 7'h00);
    send_char_item({1'b0, CH_EOT});
    send_char_item({1'b1, CH_EOT});
    drain();
    set_modes(0, 1, 0, 0, 0, 0, 0, 7'h00);
    send_char_item({1'b0, CH_EOT});
    send_char_item({1'b0, CH_BS});
    send_char_item({1'b0, CH_DEL});
    drain();
  endtask

  task automatic test_delay_classes();
    // newline, tab and return type one, vertical delay on
    set_modes(0, 0, 0, 0, 0, 0, 0, 7'h55);
    send_char_item(8'h41);
    send_char_item(8'h42);
    send_char_item({1'b0, CH_TAB});
    send_char_item({1'b0, CH_LF});
    send_char_item({1'b0, CH_VT});
    send_char_item({1'b0, CH_CR});
    drain();
    // type two everywhere
    set_modes(0, 0, 0, 0, 0, 0, 0, 7'h6A);
    send_char_item({1'b0, CH_LF});
    send_char_item({1'b0, CH_CR});
    send_char_item({1'b0, CH_FF});
    drain();
  endtask

  task automatic test_upper_case_escapes();
    set_modes(0, 0, 0, 1, 1, 0, 1, 7'h00);
    send_char_item({1'b0, CH_LBRACE});
    send_char_item({1'b0, CH_RBRACE});
    send_char_item({1'b0, CH_BAR});
    send_char_item({1'b0, CH_TILDE});
    send_char_item({1'b0, CH_GRAVE});
    send_char_item(8'h71);
    send_char_item({1'b0, CH_CAP_Z});
    drain();
  endtask

  task automatic test_newline_and_tilde();
    set_modes(0, 0, 0, 0, 0, 1, 1, 7'h16);
    send_char_item(8'h78);
    send_char_item({1'b0, CH_TILDE});
    send_char_item({1'b0, CH_LF});
    drain();
  endtask

  task automatic test_tab_expansion();
    set_modes(0, 0, 1, 0, 0, 0, 0, 7'h04);
    send_char_item({1'b0, CH_TAB});
    send_char_item(8'h78);
    send_char_item({1'b0, CH_TAB});
    drain();
  endtask

  // Run a line out to the last column, then poke the saturated column.
  task automatic test_column_saturation();
    set_modes(0, 0, 1, 0, 0, 0, 1'($urandom), 7'h05);
    while (print_col != 8'd255) begin
      if ($urandom_range(2) != 0) send_char_item({1'b0, CH_TAB});
      else send_char_item(8'($urandom_range(8'h7E, 8'h21)));
    end
    send_char_item({1'b0, CH_TAB});
    send_char_item(8'h2A);
    drain();
    set_modes(0, 0, 0, 0, 0, 0, 0, 7'h45);
    send_char_item({1'b0, CH_TAB});
    send_char_item({1'b0, CH_BS});
    send_char_item(8'h61);
    send_char_item(8'h62);
    send_char_item({1'b0, CH_LF});
    drain();
  endtask

  task automatic test_random_text(input int count);
    repeat (count) send_char_item(pick_char());
    drain();
  endtask

  // Hold the receiver off while the sender keeps pushing characters.
  task automatic test_output_backpressure();
    set_modes(0, 1, 0, 1'($urandom), 1'($urandom), 1, 1'($urandom), 7'h7F);
    steady_in  = 1;
    stall_left = 200;
    repeat (30) send_char_item(pick_char());
    steady_in = 0;
    drain();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.out_char = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    {binary_on, raw_on, tabs_on, upper_on, caps_on, crnl_on, tilde_on} = '0;
    delay_sel = '0;
    print_col = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_binary_passthrough();
    test_eot_and_controls();
    test_delay_classes();
    test_upper_case_escapes();
    test_newline_and_tilde();
    test_tab_expansion();
    test_column_saturation();

    // everything on but binary, no idling on either side
    steady_in  = 1;
    steady_out = 1;
    set_modes(0, 1, 1, 1, 1, 1, 1, 7'h7F);
    test_random_text(30);
    steady_in  = 0;
    steady_out = 0;
    set_modes(0, 0, 0, 0, 0, 0, 0, 7'h00);
    test_random_text(10);
    set_random_modes(1);
    test_random_text(10);
    set_random_modes(1);
    test_random_text(10);
    test_output_backpressure();

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && line_bytes_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
